>>> hdl/cb40_pkg.sv
// shared types, constants and character mapping functions for the base-40 callsign codec
package cb40_pkg;

	localparam int NUM_CHARS  = 9;
	localparam int CHAR_W     = 8;
	localparam int DIGIT_W    = 6;
	localparam int LEN_W      = 4;
	localparam int ADDR_W     = 48;
	localparam int DEC_BITS   = 4;
	localparam int DEC_STEPS  = ADDR_W / DEC_BITS;
	localparam int CNT_W      = 4;
	localparam int TDATA_W    = 128;

	localparam logic [DIGIT_W-1:0] DIGIT_HALF = 6'd20;
	localparam logic [DIGIT_W-1:0] DIGIT_ADJ  = 6'd12;

	localparam logic [ADDR_W-1:0] ADDR_LIMIT = 48'd262144000000000;
	localparam logic [ADDR_W-1:0] ADDR_BCAST = 48'hFFFF_FFFF_FFFF;

	localparam logic [LEN_W-1:0] MAX_LEN   = 4'd9;
	localparam logic [LEN_W-1:0] BCAST_LEN = 4'd3;

	localparam logic ACTION_ENCODE = 1'b0;
	localparam logic ACTION_DECODE = 1'b1;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CH_L     = 8'h4C;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic out_free;
	} stat_t;

	typedef logic [NUM_CHARS-1:0][CHAR_W-1:0]  chars_t;
	typedef logic [NUM_CHARS-1:0][DIGIT_W-1:0] digits_t;

	function automatic logic [DIGIT_W-1:0] char_to_digit(input logic [CHAR_W-1:0] c);
		logic [DIGIT_W-1:0] d;
		d = '0;
		if (c inside {[8'h41:8'h5A]}) begin
			d = DIGIT_W'(c - 8'h40);
		end else if (c inside {[8'h30:8'h39]}) begin
			d = DIGIT_W'(c - 8'h15);
		end else begin
			case (c)
				8'h2D:   d = 6'd37;
				8'h2F:   d = 6'd38;
				8'h2E:   d = 6'd39;
				default: d = '0;
			endcase
		end
		return d;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		c = '0;
		if (d == '0) begin
			c = CH_SPACE;
		end else if (d inside {[6'd1:6'd26]}) begin
			c = 8'h40 + CHAR_W'(d);
		end else if (d inside {[6'd27:6'd36]}) begin
			c = 8'h15 + CHAR_W'(d);
		end else begin
			case (d)
				6'd37:   c = 8'h2D;
				6'd38:   c = 8'h2F;
				6'd39:   c = 8'h2E;
				default: c = '0;
			endcase
		end
		return c;
	endfunction

endpackage

>>> hdl/callsign_base40_codec_top.sv
// top level of the base-40 callsign codec with stream ports
// encode clamps len to 9; broadcast text or an out-of-range address skips the digit steps
// one item at a time: next input taken only after the result enters the output register
// decode runs 12 steps of 4 address bits through the base-40 digit register, encode one
// character per cycle through the multiply-by-40 accumulator
// arst_n clears the state machine and output valid, no result pending after reset
module callsign_base40_codec_top
	import cb40_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,  // text_char_0..text_char_8, text_length, code_in
	input  logic [0:0]         s_tuser,  // action
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // code_out, name_char_0..name_char_8, name_length
	output logic [0:0]         m_tuser   // broadcast
);

	localparam int LEN_LSB  = NUM_CHARS * CHAR_W;
	localparam int CODE_LSB = LEN_LSB + LEN_W;
	localparam int PAD_W    = TDATA_W - ADDR_W - NUM_CHARS * CHAR_W - LEN_W;

	cmd_t               cmd;
	stat_t              stat;
	chars_t             in_chars;
	chars_t             out_chars;
	logic [ADDR_W-1:0]  out_code;
	logic [LEN_W-1:0]   out_len;
	logic               out_bcast;

	assign in_chars = s_tdata[LEN_LSB-1:0];

	cb40_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cb40_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_action (s_tuser[0]),
		.in_chars  (in_chars),
		.in_len    (s_tdata[CODE_LSB-1:LEN_LSB]),
		.in_code   (s_tdata[CODE_LSB+ADDR_W-1:CODE_LSB]),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_code  (out_code),
		.out_chars (out_chars),
		.out_len   (out_len),
		.out_bcast (out_bcast)
	);

	assign m_tdata = {{PAD_W{1'b0}}, out_len, out_chars, out_code};
	assign m_tuser = out_bcast;

endmodule

>>> hdl/cb40_ctrl.sv
// controller state machine sequencing load, digit steps and result transfer
module cb40_ctrl
	import cb40_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (stat.cnt_zero && stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_RUN: begin
				cmd.step     = !stat.cnt_zero;
				cmd.out_load = stat.cnt_zero && stat.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

>>> hdl/cb40_dp.sv
// datapath: horner encoder, shift-and-adjust base-40 decoder and result register
module cb40_dp
	import cb40_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic               in_action,
	input  chars_t             in_chars,
	input  logic [LEN_W-1:0]   in_len,
	input  logic [ADDR_W-1:0]  in_code,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [ADDR_W-1:0]  out_code,
	output chars_t             out_chars,
	output logic [LEN_W-1:0]   out_len,
	output logic               out_bcast
);

	logic               mode_q;
	logic               bcast_q;
	logic               skip_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ADDR_W-1:0]  work_q;
	chars_t             chars_q;
	digits_t            acc_q;
	logic               valid_q;
	logic [ADDR_W-1:0]  res_code_q;
	chars_t             res_chars_q;
	logic [LEN_W-1:0]   res_len_q;
	logic               res_bcast_q;

	logic [LEN_W-1:0]   len_c;
	logic               enc_all;
	logic [CNT_W-1:0]   enc_idx;
	logic [DIGIT_W-1:0] enc_digit;
	digits_t            acc_nxt;
	digits_t            adj;
	logic [LEN_W-1:0]   dec_len;
	chars_t             name_nxt;
	logic [LEN_W-1:0]   len_nxt;

	// load-time checks
	always_comb begin
		len_c   = (in_len > MAX_LEN) ? MAX_LEN : in_len;
		enc_all = (len_c == BCAST_LEN || len_c == MAX_LEN) && in_chars[0] == CH_A &&
			in_chars[1] == CH_L && in_chars[2] == CH_L;
		if (len_c == MAX_LEN) begin
			for (int i = 3; i < NUM_CHARS; i++) begin
				if (in_chars[i] != CH_SPACE) begin
					enc_all = 1'b0;
				end
			end
		end
	end

	assign enc_idx   = cnt_q - CNT_W'(1);
	assign enc_digit = char_to_digit(chars_q[enc_idx]);

	// binary to base-40, one address bit per inner pass
	always_comb begin
		acc_nxt = acc_q;
		adj     = acc_q;
		for (int b = 0; b < DEC_BITS; b++) begin
			for (int k = 0; k < NUM_CHARS; k++) begin
				adj[k] = (acc_nxt[k] >= DIGIT_HALF) ? acc_nxt[k] + DIGIT_ADJ : acc_nxt[k];
			end
			acc_nxt[0] = {adj[0][DIGIT_W-2:0], work_q[ADDR_W-1-b]};
			for (int k = 1; k < NUM_CHARS; k++) begin
				acc_nxt[k] = {adj[k][DIGIT_W-2:0], adj[k-1][DIGIT_W-1]};
			end
		end
	end

	always_comb begin
		dec_len = '0;
		for (int k = 0; k < NUM_CHARS; k++) begin
			if (acc_q[k] != '0) begin
				dec_len = LEN_W'(k + 1);
			end
		end
	end

	always_comb begin
		name_nxt = '0;
		len_nxt  = '0;
		if (mode_q == ACTION_DECODE) begin
			if (bcast_q) begin
				name_nxt[0] = CH_A;
				name_nxt[1] = CH_L;
				name_nxt[2] = CH_L;
				len_nxt     = BCAST_LEN;
			end else if (!skip_q) begin
				for (int k = 0; k < NUM_CHARS; k++) begin
					if (LEN_W'(k) < dec_len) begin
						name_nxt[k] = digit_to_char(acc_q[k]);
					end
				end
				len_nxt = dec_len;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= in_action;
			chars_q <= in_chars;
			acc_q   <= '0;
			if (in_action == ACTION_ENCODE) begin
				work_q  <= enc_all ? ADDR_BCAST : '0;
				bcast_q <= 1'b0;
				skip_q  <= 1'b0;
				cnt_q   <= enc_all ? '0 : CNT_W'(len_c);
			end else begin
				work_q  <= in_code;
				bcast_q <= (in_code == ADDR_BCAST);
				skip_q  <= (in_code >= ADDR_LIMIT);
				cnt_q   <= (in_code >= ADDR_LIMIT) ? '0 : CNT_W'(DEC_STEPS);
			end
		end else if (cmd.step) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (mode_q == ACTION_ENCODE) begin
				work_q <= (work_q << 5) + (work_q << 3) + ADDR_W'(enc_digit);
			end else begin
				acc_q  <= acc_nxt;
				work_q <= work_q << DEC_BITS;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_code_q  <= (mode_q == ACTION_ENCODE) ? work_q : '0;
			res_chars_q <= name_nxt;
			res_len_q   <= len_nxt;
			res_bcast_q <= (mode_q == ACTION_DECODE) && bcast_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid     = valid_q;
	assign out_code      = res_code_q;
	assign out_chars     = res_chars_q;
	assign out_len       = res_len_q;
	assign out_bcast     = res_bcast_q;
	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.out_free = !valid_q || out_ready;

endmodule

>>> hdl/cb40_chk.sv
// port-level checker for the codec top level, attached by bind
module cb40_chk
	import cb40_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic [0:0]         m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	a_bcast_name: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[123:120] == BCAST_LEN &&
		m_tdata[ADDR_W-1:0] == '0 && m_tdata[55:48] == CH_A)
		else $error("broadcast result without ALL name");

	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[ADDR_W-1:0] == '0 || m_tdata[123:120] == '0)
		else $error("result carries both address and name");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[123:120] <= MAX_LEN && m_tdata[127:124] == '0)
		else $error("name length out of range");

endmodule

bind callsign_base40_codec_top cb40_chk u_chk (.*);
